[rtl/dfs_pkg.sv]
`default_nettype none

package dfs_pkg;

    // Geometry and field widths
    localparam int DIM_W       = 13;
    localparam int MAX_DIM     = 4096;
    localparam int PIX_W       = 8;
    localparam int FRAME_W     = 8;
    localparam int MEAN_W      = 16;
    localparam int MEAN_FRAC   = 8;
    localparam int THRESH_W    = 8;
    localparam int LIMIT_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam int GRID_DIVISOR_DEF = 32;
    localparam int QUEUE_DEPTH      = 2;

    // Rec.601 integer luma weights, scaled by 256
    localparam int LUMA_R = 77;
    localparam int LUMA_G = 150;
    localparam int LUMA_B = 29;

    // Register reset values
    localparam int WIDTH_RST  = 1920;
    localparam int HEIGHT_RST = 1080;
    localparam int THRESH_RST = 16;
    localparam int LIMIT_RST  = 60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT    = 2'd1,
        CFG_BLACK_THRESHOLD = 2'd2,
        CFG_MAX_FRAMES      = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DEC_SEARCH = 2'd0,
        DEC_BRIGHT = 2'd1,
        DEC_LIMIT  = 2'd2
    } decision_t;

    // Clamped frame size and grid step per axis
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] step_x;
        logic [DIM_W-1:0] step_y;
    } geometry_t;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [LIMIT_W-1:0]  max_frames;
    } search_cfg_t;

    // Samples per frame stay below (2*divisor)^2
    function automatic int sample_count_width(input int grid_divisor);
        return $clog2(4 * grid_divisor * grid_divisor) + 1;
    endfunction

endpackage

`default_nettype wire

[rtl/dfs_if.sv]
`default_nettype none

interface dfs_pixel_if import dfs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface dfs_result_if import dfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_number;
    logic [MEAN_W-1:0]  mean_luma_q8;
    decision_t          decision;
    logic [FRAME_W-1:0] chosen_frame;

    modport source (output valid, output frame_number, output mean_luma_q8,
                    output decision, output chosen_frame, input ready);
    modport sink   (input valid, input frame_number, input mean_luma_q8,
                    input decision, input chosen_frame, output ready);
endinterface

`default_nettype wire

[rtl/dfs_front.sv]
`default_nettype none

module dfs_front import dfs_pkg::*; #(
    parameter int GRID_DIVISOR = GRID_DIVISOR_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    dfs_pixel_if.sink              pixel,
    input  geometry_t              geom,
    input  wire logic              push_ready,
    output logic                   push_valid,
    output logic [sample_count_width(GRID_DIVISOR)+PIX_W-1:0] push_sum,
    output logic [sample_count_width(GRID_DIVISOR)-1:0]       push_count
);

    localparam int CNT_W    = sample_count_width(GRID_DIVISOR);
    localparam int SUM_W    = CNT_W + PIX_W;
    localparam int MAX_STEP = MAX_DIM / GRID_DIVISOR;
    localparam int PH_W     = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int POS_W    = DIM_W - 1;

    logic [POS_W-1:0] col_cnt_reg, col_cnt_next;
    logic [POS_W-1:0] row_cnt_reg, row_cnt_next;
    logic [PH_W-1:0]  col_phase_reg, col_phase_next;
    logic [PH_W-1:0]  row_phase_reg, row_phase_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             accept;
    logic             sample;
    logic [15:0]      luma_full;
    logic [PIX_W-1:0] luma;
    logic [SUM_W-1:0] sum_acc;
    logic [CNT_W-1:0] cnt_acc;
    logic [DIM_W-1:0] col_inc, row_inc, colph_inc, rowph_inc;
    logic             col_end, row_end, frame_end;

    assign accept      = pixel.valid && pixel.ready;
    assign pixel.ready = push_ready;

    always_comb
    begin
        sample    = (col_phase_reg == '0) && (row_phase_reg == '0);
        luma_full = 16'(pixel.red)   * 16'(LUMA_R)
                  + 16'(pixel.green) * 16'(LUMA_G)
                  + 16'(pixel.blue)  * 16'(LUMA_B);
        luma      = luma_full[15:8];
        sum_acc   = sum_reg + (sample ? SUM_W'(luma) : '0);
        cnt_acc   = cnt_reg + CNT_W'(sample);

        // Bounds tested with >= so a shrunk size ends the line at once
        col_inc   = DIM_W'(col_cnt_reg) + DIM_W'(1);
        row_inc   = DIM_W'(row_cnt_reg) + DIM_W'(1);
        colph_inc = DIM_W'(col_phase_reg) + DIM_W'(1);
        rowph_inc = DIM_W'(row_phase_reg) + DIM_W'(1);
        col_end   = col_inc >= geom.width;
        row_end   = row_inc >= geom.height;
        frame_end = col_end && row_end;

        col_cnt_next   = col_end ? '0 : col_inc[POS_W-1:0];
        col_phase_next = (col_end || colph_inc >= geom.step_x) ? '0 : colph_inc[PH_W-1:0];
        row_cnt_next   = row_cnt_reg;
        row_phase_next = row_phase_reg;
        if (col_end)
        begin
            row_cnt_next   = row_end ? '0 : row_inc[POS_W-1:0];
            row_phase_next = (row_end || rowph_inc >= geom.step_y) ? '0 : rowph_inc[PH_W-1:0];
        end
        sum_next = frame_end ? '0 : sum_acc;
        cnt_next = frame_end ? '0 : cnt_acc;
    end

    assign push_valid = accept && frame_end;
    assign push_sum   = sum_acc;
    assign push_count = cnt_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/dfs_fifo.sv]
`default_nettype none

module dfs_fifo import dfs_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   not_full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign not_full  = fill_reg != FILL_W'(DEPTH);
    assign pop_valid = fill_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/dfs_back.sv]
`default_nettype none

module dfs_back import dfs_pkg::*; #(
    parameter int GRID_DIVISOR = GRID_DIVISOR_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire logic [sample_count_width(GRID_DIVISOR)+PIX_W-1:0] q_sum,
    input  wire logic [sample_count_width(GRID_DIVISOR)-1:0]       q_count,
    output logic                   q_pop,
    input  search_cfg_t            cfg,
    dfs_result_if.source           result
);

    localparam int CNT_W   = sample_count_width(GRID_DIVISOR);
    localparam int SUM_W   = CNT_W + PIX_W;
    localparam int STEP_W  = $clog2(MEAN_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   divisor_reg, divisor_next;
    logic [MEAN_W-1:0]  shreg_reg, shreg_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   prod_reg, prod_next;

    logic [FRAME_W-1:0] frames_seen_reg, frames_seen_next;
    logic [MEAN_W-1:0]  best_mean_reg, best_mean_next;
    logic [FRAME_W-1:0] best_frame_reg, best_frame_next;
    logic               best_valid_reg, best_valid_next;

    logic               res_valid_reg, res_valid_next;
    logic [FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic [MEAN_W-1:0]  res_mean_reg, res_mean_next;
    decision_t          res_dec_reg, res_dec_next;
    logic [FRAME_W-1:0] res_chosen_reg, res_chosen_next;

    logic [CNT_W:0]     trial;
    logic               trial_ge;
    logic               finish;
    logic               take_best, bright, hit_limit;
    logic [FRAME_W-1:0] fs_inc;
    logic [LIMIT_W-1:0] limit;
    logic [FRAME_W-1:0] best_frame_upd;
    logic [MEAN_W-1:0]  best_mean_upd;

    assign result.valid        = res_valid_reg;
    assign result.frame_number = res_frame_reg;
    assign result.mean_luma_q8 = res_mean_reg;
    assign result.decision     = res_dec_reg;
    assign result.chosen_frame = res_chosen_reg;

    always_comb
    begin
        state_next       = state_reg;
        rem_next         = rem_reg;
        divisor_next     = divisor_reg;
        shreg_next       = shreg_reg;
        step_next        = step_reg;
        sum_next         = sum_reg;
        prod_next        = prod_reg;
        frames_seen_next = frames_seen_reg;
        best_mean_next   = best_mean_reg;
        best_frame_next  = best_frame_reg;
        best_valid_next  = best_valid_reg;
        res_frame_next   = res_frame_reg;
        res_mean_next    = res_mean_reg;
        res_dec_next     = res_dec_reg;
        res_chosen_next  = res_chosen_reg;
        res_valid_next   = res_valid_reg && !result.ready;
        q_pop            = 1'b0;
        finish           = 1'b0;

        // Restoring divide step: one quotient bit of sum*256/count
        trial    = {rem_reg, shreg_reg[MEAN_W-1]};
        trial_ge = trial >= {1'b0, divisor_reg};

        // Search bookkeeping for the frame in the divider
        take_best      = !best_valid_reg || (shreg_reg > best_mean_reg);
        best_mean_upd  = take_best ? shreg_reg : best_mean_reg;
        best_frame_upd = take_best ? frames_seen_reg : best_frame_reg;
        bright         = sum_reg >= prod_reg;
        fs_inc         = frames_seen_reg + FRAME_W'(1);
        limit          = (cfg.max_frames == '0) ? LIMIT_W'(1) : cfg.max_frames;
        hit_limit      = (fs_inc >= limit) || (fs_inc == '0);

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    // Quotient fits 16 bits, so the top dividend bits are below count
                    rem_next     = q_sum[SUM_W-1:MEAN_FRAC];
                    shreg_next   = {q_sum[MEAN_FRAC-1:0], MEAN_FRAC'(0)};
                    divisor_next = q_count;
                    sum_next     = q_sum;
                    prod_next    = SUM_W'(cfg.threshold) * SUM_W'(q_count);
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next   = trial_ge ? CNT_W'(trial - {1'b0, divisor_reg})
                                      : trial[CNT_W-1:0];
                shreg_next = {shreg_reg[MEAN_W-2:0], trial_ge};
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MEAN_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                finish = !res_valid_reg || result.ready;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next      = ST_IDLE;
            res_valid_next  = 1'b1;
            res_frame_next  = frames_seen_reg;
            res_mean_next   = shreg_reg;
            best_mean_next  = best_mean_upd;
            best_frame_next = best_frame_upd;
            best_valid_next = 1'b1;
            if (bright)
            begin
                res_dec_next    = DEC_BRIGHT;
                res_chosen_next = frames_seen_reg;
            end
            else if (hit_limit)
            begin
                res_dec_next    = DEC_LIMIT;
                res_chosen_next = best_frame_upd;
            end
            else
            begin
                res_dec_next     = DEC_SEARCH;
                res_chosen_next  = '0;
                frames_seen_next = fs_inc;
            end
            if (bright || hit_limit)
            begin
                frames_seen_next = '0;
                best_mean_next   = '0;
                best_frame_next  = '0;
                best_valid_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        shreg_reg      <= shreg_next;
        sum_reg        <= sum_next;
        prod_reg       <= prod_next;
        res_frame_reg  <= res_frame_next;
        res_mean_reg   <= res_mean_next;
        res_dec_reg    <= res_dec_next;
        res_chosen_reg <= res_chosen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            frames_seen_reg <= '0;
            best_mean_reg   <= '0;
            best_frame_reg  <= '0;
            best_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            frames_seen_reg <= frames_seen_next;
            best_mean_reg   <= best_mean_next;
            best_frame_reg  <= best_frame_next;
            best_valid_reg  <= best_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/dark_frame_skip_selector_unit.sv]
// Channel   Dir  Transaction                 Payload
// pixel     in   one RGB pixel, raster order red, green, blue (8 b each)
// result    out  one per frame end           frame_number, mean_luma_q8, decision,
//                                            chosen_frame
// cfg_*     in   write, no handshake         cfg_index selects the register
//
// Pixels are taken one per cycle while the frame-total queue has room.
// Each frame's totals pass through the frame-total queue; the back end pops them,
// runs the bit-serial mean divider, then settles the search and registers the result.
// The back end works on one frame total at a time; pixel ready drops
// only when two queued frames are waiting behind it.
// Reset (rst_n, async, low) loads register defaults; no clearing pass.
`default_nettype none

module dark_frame_skip_selector_unit import dfs_pkg::*; #(
    parameter int GRID_DIVISOR = GRID_DIVISOR_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dfs_pixel_if.sink                  pixel,
    dfs_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = sample_count_width(GRID_DIVISOR);
    localparam int SUM_W = CNT_W + PIX_W;
    localparam int Q_W   = SUM_W + CNT_W;

    // Grid step = size / GRID_DIVISOR by reciprocal multiply; exact for 13-bit sizes
    localparam int RECIP_SH  = DIM_W + $clog2(GRID_DIVISOR);
    localparam int RECIP_MUL = ((2 ** RECIP_SH) + GRID_DIVISOR - 1) / GRID_DIVISOR;
    localparam int MUL_W     = DIM_W + 2;
    localparam int PROD_W    = DIM_W + MUL_W;

    localparam logic [DIM_W-1:0] STEP_X_RST =
        DIM_W'(((WIDTH_RST / GRID_DIVISOR) == 0) ? 1 : (WIDTH_RST / GRID_DIVISOR));
    localparam logic [DIM_W-1:0] STEP_Y_RST =
        DIM_W'(((HEIGHT_RST / GRID_DIVISOR) == 0) ? 1 : (HEIGHT_RST / GRID_DIVISOR));

    geometry_t   geom_reg;
    search_cfg_t search_reg;

    logic [DIM_W-1:0] cfg_dim;
    logic [DIM_W-1:0] cfg_step;
    logic [PROD_W-1:0] step_prod;

    logic             push_valid, push_ready;
    logic [SUM_W-1:0] push_sum;
    logic [CNT_W-1:0] push_count;
    logic             q_valid, q_pop;
    logic [Q_W-1:0]   q_data;

    // Sizes of zero act as one, sizes above 4096 as 4096
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_dim = DIM_W'(1);
        end
        else if (DIM_W'(cfg_data) > DIM_W'(MAX_DIM))
        begin
            cfg_dim = DIM_W'(MAX_DIM);
        end
        else
        begin
            cfg_dim = DIM_W'(cfg_data);
        end
        step_prod = PROD_W'(cfg_dim) * PROD_W'(RECIP_MUL);
        cfg_step  = DIM_W'(step_prod >> RECIP_SH);
        if (cfg_step == '0)
        begin
            cfg_step = DIM_W'(1);
        end
    end

    // Step is worked out when the size is written, so it applies from the next pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.width        <= DIM_W'(WIDTH_RST);
            geom_reg.height       <= DIM_W'(HEIGHT_RST);
            geom_reg.step_x       <= STEP_X_RST;
            geom_reg.step_y       <= STEP_Y_RST;
            search_reg.threshold  <= THRESH_W'(THRESH_RST);
            search_reg.max_frames <= LIMIT_W'(LIMIT_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:
                begin
                    geom_reg.width  <= cfg_dim;
                    geom_reg.step_x <= cfg_step;
                end
                CFG_FRAME_HEIGHT:
                begin
                    geom_reg.height <= cfg_dim;
                    geom_reg.step_y <= cfg_step;
                end
                CFG_BLACK_THRESHOLD:
                begin
                    search_reg.threshold <= cfg_data[THRESH_W-1:0];
                end
                CFG_MAX_FRAMES:
                begin
                    search_reg.max_frames <= cfg_data[LIMIT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Front: grid sampling, luma and per-frame totals
    dfs_front #(
        .GRID_DIVISOR (GRID_DIVISOR)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .geom       (geom_reg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_sum   (push_sum),
        .push_count (push_count)
    );

    // Frame totals wait here while the divider is busy
    dfs_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data ({push_sum, push_count}),
        .not_full  (push_ready),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    // Back: mean divider, threshold test and brightest-frame search
    dfs_back #(
        .GRID_DIVISOR (GRID_DIVISOR)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_sum   (q_data[Q_W-1:CNT_W]),
        .q_count (q_data[CNT_W-1:0]),
        .q_pop   (q_pop),
        .cfg     (search_reg),
        .result  (result)
    );

endmodule

`default_nettype wire

[rtl/dfs_checker.sv]
`default_nettype none

module dfs_checker import dfs_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic [FRAME_W-1:0] frame_number,
    input wire logic [MEAN_W-1:0]  mean_luma_q8,
    input wire logic [1:0]         decision,
    input wire logic [FRAME_W-1:0] chosen_frame
);

    logic [FRAME_W-1:0] frame_exp_reg;

    // Frame index runs on by one while searching and restarts after a decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_exp_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            frame_exp_reg <= (decision == DEC_SEARCH) ? frame_number + FRAME_W'(1) : '0;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
            $stable({frame_number, mean_luma_q8, decision, chosen_frame}))
        else $error("result changed while stalled");

    a_frame_seq: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |-> frame_number == frame_exp_reg)
        else $error("frame number out of sequence");

    a_search_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && decision == DEC_SEARCH |-> chosen_frame == '0)
        else $error("chosen frame set while searching");

    a_bright_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && decision == DEC_BRIGHT |-> chosen_frame == frame_number)
        else $error("bright decision names another frame");

    a_limit_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && decision == DEC_LIMIT |-> chosen_frame <= frame_number)
        else $error("fallback names a frame not yet seen");

endmodule

bind dark_frame_skip_selector_unit dfs_checker u_dfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .frame_number (result.frame_number),
    .mean_luma_q8 (result.mean_luma_q8),
    .decision     (result.decision),
    .chosen_frame (result.chosen_frame)
);

`default_nettype wire

[bench/dark_frame_skip_selector_unit_tb.sv]
`default_nettype none

// Bench for the dark-frame skip selector.
// Pixels are fed from a backlog queue through a clocked driver; every accepted
// pixel transaction updates a local predictor of the frame statistics and the
// search. Each frame end it predicts queues one verdict. A clocked observer
// compares every accepted result transaction with the oldest queued verdict.
module dark_frame_skip_selector_unit_tb;
    import dfs_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct {
        logic [FRAME_W-1:0] frame_number;
        logic [MEAN_W-1:0]  mean_luma_q8;
        decision_t          decision;
        logic [FRAME_W-1:0] chosen_frame;
    } frame_verdict_t;

    // Pixel flavours for stimulus; DARK and BRIGHT steer the threshold test
    typedef enum int {
        PX_ANY,
        PX_DARK,
        PX_BRIGHT,
        PX_BLACK,
        PX_WHITE
    } px_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dfs_pixel_if  pixel_ch ();
    dfs_result_if result_ch ();

    dark_frame_skip_selector_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch.sink),
        .result    (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pixels waiting to be offered, and verdicts waiting for their result transaction
    rgb_t           pixel_backlog[$];
    frame_verdict_t verdict_q[$];

    int unsigned mismatches = 0;

    // calm: no idling on either side (final stretch of the run)
    // want_hold: ask the receiver for one long hold-off
    bit calm = 1'b0;
    bit want_hold = 1'b0;

    // ------------------------------------------------------------------
    // Predictor: register shadows and search state
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]    width_reg  = DIM_W'(WIDTH_RST);
    logic [DIM_W-1:0]    height_reg = DIM_W'(HEIGHT_RST);
    logic [THRESH_W-1:0] thresh_reg = THRESH_W'(THRESH_RST);
    logic [LIMIT_W-1:0]  limit_reg  = LIMIT_W'(LIMIT_RST);

    int unsigned     col_pos = 0;
    int unsigned     row_pos = 0;
    int unsigned     col_phase = 0;
    int unsigned     row_phase = 0;
    longint unsigned luma_total = 0;
    longint unsigned sampled = 0;
    int unsigned     search_frames = 0;
    int unsigned     brightest_mean = 0;
    int unsigned     brightest_idx = 0;
    bit              brightest_seen = 1'b0;

    // Zero acts as one, anything past the largest frame acts as the largest
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic int unsigned grid_step(input int unsigned dim);
        int unsigned s;
        s = dim / GRID_DIVISOR_DEF;
        return (s == 0) ? 1 : s;
    endfunction

    function automatic void restart_search();
        search_frames  = 0;
        brightest_mean = 0;
        brightest_idx  = 0;
        brightest_seen = 1'b0;
    endfunction

    // One accepted pixel: grid sampling, raster counters, and at frame end the
    // mean, the brightest-frame tracking and the search decision.
    function automatic void tally_pixel(input rgb_t px);
        int unsigned     w;
        int unsigned     h;
        int unsigned     sx;
        int unsigned     sy;
        int unsigned     lim;
        int unsigned     idx;
        longint unsigned mean;
        bit              frame_done;
        frame_verdict_t  v;

        w   = clamp_dim(width_reg);
        h   = clamp_dim(height_reg);
        sx  = grid_step(w);
        sy  = grid_step(h);
        lim = (limit_reg == 0) ? 1 : 32'(limit_reg);
        frame_done = 1'b0;

        if (col_phase == 0 && row_phase == 0)
        begin
            luma_total += 64'((LUMA_R * px.red + LUMA_G * px.green + LUMA_B * px.blue) >> 8);
            sampled    += 1;
        end

        // Bounds are tested with >= so a shrunken size ends its period at once
        col_pos   += 1;
        col_phase += 1;
        if (col_phase >= sx)
            col_phase = 0;
        if (col_pos >= w)
        begin
            col_pos   = 0;
            col_phase = 0;
            row_pos   += 1;
            row_phase += 1;
            if (row_phase >= sy)
                row_phase = 0;
            if (row_pos >= h)
            begin
                row_pos    = 0;
                row_phase  = 0;
                frame_done = 1'b1;
            end
        end

        if (!frame_done)
            return;

        mean = (sampled == 0) ? 0 : (luma_total * 256) / sampled;
        if (mean > 64'hFFFF)
            mean = 64'hFFFF;
        idx = search_frames & 8'hFF;

        // Only a strictly brighter frame displaces the stored best
        if (!brightest_seen || mean > brightest_mean)
        begin
            brightest_mean = 32'(mean);
            brightest_idx  = idx;
            brightest_seen = 1'b1;
        end

        v.frame_number = FRAME_W'(idx);
        v.mean_luma_q8 = mean[MEAN_W-1:0];
        v.decision     = DEC_SEARCH;
        v.chosen_frame = '0;

        if (luma_total >= longint'(thresh_reg) * sampled)
        begin
            v.decision     = DEC_BRIGHT;
            v.chosen_frame = FRAME_W'(idx);
            restart_search();
        end
        else
        begin
            search_frames = (search_frames + 1) & 8'hFF;
            if (search_frames >= lim || search_frames == 0)
            begin
                v.decision     = DEC_LIMIT;
                v.chosen_frame = FRAME_W'(brightest_idx);
                restart_search();
            end
        end

        luma_total = 0;
        sampled    = 0;
        verdict_q.push_back(v);
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pixel driver: holds a transaction until taken, otherwise idles in
    // random bursts or pulls the next pixel from the backlog.
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge clk)
    begin : pixel_driver
        logic offer;
        rgb_t px;
        if (!rst_n)
        begin
            pixel_ch.valid <= 1'b0;
        end
        else if (!(pixel_ch.valid && !pixel_ch.ready))
        begin
            offer = 1'b0;
            px    = '0;
            if (send_gap > 0)
                send_gap--;
            else if (!calm && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 17) - 1;
            else if (pixel_backlog.size() != 0)
            begin
                offer = 1'b1;
                px    = pixel_backlog.pop_front();
            end
            pixel_ch.valid <= offer;
            if (offer)
            begin
                pixel_ch.red   <= px.red;
                pixel_ch.green <= px.green;
                pixel_ch.blue  <= px.blue;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off on request so
    // that the frame-total queue fills and pixel ready drops.
    // ------------------------------------------------------------------
    int unsigned take_gap = 0;
    int unsigned hold_left = 0;
    bit          hold_taken = 1'b0;

    always @(posedge clk)
    begin : result_receiver
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (want_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                result_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                take_gap = $urandom_range(1, 17) - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Observer: feeds accepted pixels to the predictor and checks results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : observer
        frame_verdict_t want;
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                tally_pixel({pixel_ch.red, pixel_ch.green, pixel_ch.blue});

            if (result_ch.valid && result_ch.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    note_mismatch("result transaction with no frame end pending");
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (result_ch.frame_number !== want.frame_number)
                        note_mismatch($sformatf("frame_number %0d, expected %0d",
                            result_ch.frame_number, want.frame_number));
                    if (result_ch.mean_luma_q8 !== want.mean_luma_q8)
                        note_mismatch($sformatf("mean_luma_q8 %0h, expected %0h",
                            result_ch.mean_luma_q8, want.mean_luma_q8));
                    if (result_ch.decision !== want.decision)
                        note_mismatch($sformatf("decision %0d, expected %0d",
                            result_ch.decision, want.decision));
                    if (result_ch.chosen_frame !== want.chosen_frame)
                        note_mismatch($sformatf("chosen_frame %0d, expected %0d",
                            result_ch.chosen_frame, want.chosen_frame));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle means every pixel taken and every verdict matched. The block may
    // still be folding in pixels of an unfinished frame, so a settling margin follows
    // before the registers are touched.
    task automatic wait_idle();
        while (pixel_backlog.size() != 0 || pixel_ch.valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_FRAME_WIDTH:     width_reg  = val;
            CFG_FRAME_HEIGHT:    height_reg = val;
            CFG_BLACK_THRESHOLD: thresh_reg = val[THRESH_W-1:0];
            CFG_MAX_FRAMES:      limit_reg  = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Drop the write enable and land on a falling edge, so backlog pushes
    // never share a time step with the driver
    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                                 input logic [CFG_DATA_W-1:0] thr,
                                 input logic [CFG_DATA_W-1:0] lim);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_BLACK_THRESHOLD, thr);
        write_reg(CFG_MAX_FRAMES, lim);
        end_writes();
    endtask

    task automatic push_rgb(input int r, input int g, input int b);
        pixel_backlog.push_back({r[7:0], g[7:0], b[7:0]});
    endtask

    function automatic rgb_t make_pixel(input px_style_t s);
        rgb_t p;
        case (s)
            PX_BLACK:  p = '0;
            PX_WHITE:  p = '1;
            PX_DARK:   p = {8'($urandom_range(0, 24)), 8'($urandom_range(0, 24)),
                            8'($urandom_range(0, 24))};
            PX_BRIGHT: p = {8'($urandom_range(180, 255)), 8'($urandom_range(180, 255)),
                            8'($urandom_range(180, 255))};
            default:   p = rgb_t'($urandom);
        endcase
        return p;
    endfunction

    task automatic push_pixels(input int unsigned n, input px_style_t s);
        repeat (n) pixel_backlog.push_back(make_pixel(s));
    endtask

    // Large frame cut short: shrink one dimension to one, so the counters
    // already past it close the frame on the next pixel
    task automatic cut_frame(input cfg_reg_t idx);
        wait_idle();
        write_reg(idx, 1);
        end_writes();
        push_pixels(1, PX_ANY);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int unsigned small_items;
        int unsigned w;
        int unsigned h;
        int unsigned frame_px;
        int unsigned n;
        int unsigned thr;
        int unsigned lim;
        px_style_t   style;

        pixel_ch.valid  = 1'b0;
        pixel_ch.red    = '0;
        pixel_ch.green  = '0;
        pixel_ch.blue   = '0;
        result_ch.ready = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_FRAME_WIDTH;
        cfg_data        = '0;
        restart_search();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- Directed ---
        // Zero threshold: every single-pixel frame is chosen straight away.
        // Black, white and each primary at full scale.
        apply_setting(1, 1, 0, 1);
        push_rgb(0, 0, 0);
        push_rgb(255, 255, 255);
        push_rgb(255, 0, 0);
        push_rgb(0, 255, 0);
        push_rgb(0, 0, 255);

        // Top threshold with a zero frame limit (behaves as one): only pure
        // white reaches 255, the rest fall back at once
        apply_setting(1, 1, 255, 0);
        push_rgb(0, 0, 0);
        push_rgb(255, 255, 255);
        push_rgb(254, 255, 255);

        // Brightest fallback: equal means keep the earlier frame; then a
        // strictly brighter frame displaces it while a later equal one does not
        apply_setting(1, 1, 255, 3);
        push_rgb(10, 10, 10);
        push_rgb(10, 10, 10);
        push_rgb(10, 10, 10);
        push_rgb(5, 5, 5);
        push_rgb(20, 20, 20);
        push_rgb(20, 20, 20);

        // Limit lowered mid-search: four frames in, a limit of two decides the fifth
        apply_setting(1, 1, 255, 255);
        push_pixels(4, PX_BLACK);
        wait_idle();
        write_reg(CFG_MAX_FRAMES, 2);
        end_writes();
        push_rgb(0, 0, 0);

        // Width shrunk mid-line: the column count already past the new bound
        // closes the line and frame on the next pixel
        apply_setting(3, 1, 255, 255);
        push_rgb(40, 80, 120);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 1);
        end_writes();
        push_rgb(200, 100, 50);

        // --- Random settings, mostly small frames ---
        // Partial frames are left behind on purpose so the next setting starts
        // mid-frame with stale counters.
        small_items = 0;
        while (small_items < 40)
        begin
            case ($urandom_range(0, 9))
                6:
                begin
                    w = $urandom_range(64, 130);    // horizontal step of 2 to 4
                    h = $urandom_range(1, 2);
                end
                7:
                begin
                    w = $urandom_range(1, 2);
                    h = $urandom_range(64, 100);    // vertical step of 2 or 3
                end
                8:
                begin
                    w = 0;                          // zero acts as one
                    h = $urandom_range(0, 5);
                end
                9:
                begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 8);
                end
                default:
                begin
                    w = $urandom_range(1, 6);
                    h = $urandom_range(1, 4);
                end
            endcase
            style = px_style_t'($urandom_range(0, 4));
            thr   = (style == PX_DARK) ? $urandom_range(0, 30) : $urandom_range(0, 255);
            lim   = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 255)
                                                : $urandom_range(0, 6);
            frame_px = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            n = $urandom_range(1, 6) * frame_px + $urandom_range(0, frame_px - 1);
            if (n > 120)
                n = 120;
            apply_setting(CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(thr),
                          CFG_DATA_W'(lim));
            push_pixels(n, style);
            small_items += n;
        end

        // Longest search: 255 dark frames run into the top limit
        apply_setting(1, 1, 255, 255);
        push_pixels(256, PX_DARK);

        // Size extremes: full width, oversized width with zero height, zero
        // width with full height. Each frame takes the second grid sample at
        // step 128, then is closed early by shrinking the size.
        apply_setting(4096, 1, CFG_DATA_W'($urandom_range(0, 255)), 1);
        push_pixels(129, PX_ANY);
        cut_frame(CFG_FRAME_WIDTH);
        apply_setting(8191, 0, CFG_DATA_W'($urandom_range(0, 255)), 1);
        push_pixels(129, PX_ANY);
        cut_frame(CFG_FRAME_WIDTH);
        apply_setting(0, 4096, CFG_DATA_W'($urandom_range(0, 255)), 1);
        push_pixels(129, PX_ANY);
        cut_frame(CFG_FRAME_HEIGHT);

        // Back-pressure: receiver holds off while one-pixel frames keep coming,
        // so the frame-total queue fills and the pixel side stalls
        apply_setting(1, 1, CFG_DATA_W'($urandom_range(0, 255)), 4);
        want_hold = 1'b1;
        push_pixels(40, PX_ANY);

        // Final stretch with no idling on either side
        apply_setting(3, 2, 100, 3);
        calm = 1'b1;
        push_pixels(30, PX_ANY);

        while (pixel_backlog.size() != 0 || pixel_ch.valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: a correct run is well under a tenth of this
    initial
    begin : watchdog
        #8000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

[dark_frame_skip_selector_unit.f]
rtl/dfs_pkg.sv
rtl/dfs_if.sv
rtl/dfs_front.sv
rtl/dfs_fifo.sv
rtl/dfs_back.sv
rtl/dark_frame_skip_selector_unit.sv
rtl/dfs_checker.sv
bench/dark_frame_skip_selector_unit_tb.sv
